@@ design/pls_pkg.sv @@
package pls_pkg;

   localparam int VALUE_W = 32;
   localparam int POS_W   = 7;
   localparam int COUNT_W = 7;
   localparam int KIND_W  = 2;
   localparam int STAT_W  = 2;

   localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;

   localparam logic [STAT_W-1:0] STAT_DONE  = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   typedef struct packed {
      logic [KIND_W-1:0]         req_type;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] item_value;
   } req_item_type;

   typedef struct packed {
      logic [STAT_W-1:0]         status;
      logic signed [VALUE_W-1:0] out_value;
      logic [COUNT_W-1:0]        entry_count;
   } rsp_item_type;

   typedef struct packed {
      logic insert_go;
      logic remove_go;
      logic pick_go;
   } cell_ctl_type;

endpackage

@@ design/pls_cell.sv @@
module pls_cell #(
   parameter int INDEX = 0,
   parameter int PW    = 7
) (
   input  logic                                 clock,
   input  pls_pkg::cell_ctl_type                ctl,
   input  logic [PW-1:0]                        pos,
   input  logic signed [pls_pkg::VALUE_W-1:0]   left_value,
   input  logic signed [pls_pkg::VALUE_W-1:0]   right_value,
   input  logic signed [pls_pkg::VALUE_W-1:0]   new_value,
   output logic signed [pls_pkg::VALUE_W-1:0]   entry,
   output logic signed [pls_pkg::VALUE_W-1:0]   pick
);

   localparam logic [PW-1:0] MY_INDEX = PW'(INDEX);

   logic signed [pls_pkg::VALUE_W-1:0] entry_ff;
   logic signed [pls_pkg::VALUE_W-1:0] entry_in;
   logic                               hit;
   logic                               below;

   assign hit   = (pos == MY_INDEX);
   assign below = (pos < MY_INDEX);

   // An insert pulls from the lower neighbor above the position, a remove from the
   // upper neighbor at and above it.
   always_comb begin
      entry_in = entry_ff;
      if (ctl.insert_go) begin
         if (hit) begin
            entry_in = new_value;
         end else if (below) begin
            entry_in = left_value;
         end
      end else if (ctl.remove_go) begin
         if (hit || below) begin
            entry_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;
   assign pick  = (hit && ctl.pick_go) ? entry_ff : '0;

endmodule

@@ design/positional_list_store.sv @@
// The result strobe comes in the cycle after the request is accepted.
// A new request is not taken while one is pending; busy is high during the result cycle,
// while the read value is gathered from per-group registers of the cell row.
// Reset clears the entry count and the pending flag; the cells hold no reset value.
// The receiver cannot stall: each result is shown for exactly one cycle.
module positional_list_store #(
   parameter int DEPTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  pls_pkg::req_item_type req_item,
   output logic                  rsp_strobe,
   output pls_pkg::rsp_item_type rsp_item
);

   localparam int CW     = $clog2(DEPTH + 1);
   localparam int PW     = (CW > pls_pkg::POS_W) ? CW : pls_pkg::POS_W;
   localparam int GROUP  = 32;
   localparam int GROUPS = (DEPTH + GROUP - 1) / GROUP;
   localparam logic [PW-1:0] FULL_MARK = PW'(DEPTH);

   logic                        pend_ff;
   logic [CW-1:0]               count_ff;
   logic [CW-1:0]               count_in;
   logic [pls_pkg::STAT_W-1:0]  status_ff;
   logic [pls_pkg::STAT_W-1:0]  status_in;
   logic                        accept;
   logic [PW-1:0]               pos;
   logic [PW-1:0]               count_ext;
   pls_pkg::cell_ctl_type       ctl;

   logic signed [pls_pkg::VALUE_W-1:0] cell_entry [DEPTH];
   logic signed [pls_pkg::VALUE_W-1:0] cell_pick  [DEPTH];
   logic signed [pls_pkg::VALUE_W-1:0] pick_pad   [GROUPS*GROUP];
   logic signed [pls_pkg::VALUE_W-1:0] group_ff   [GROUPS];
   logic signed [pls_pkg::VALUE_W-1:0] group_in   [GROUPS];
   logic signed [pls_pkg::VALUE_W-1:0] value_out;

   assign accept    = start && !pend_ff;
   assign busy      = pend_ff;
   assign pos       = PW'(req_item.position);
   assign count_ext = PW'(count_ff);

   always_comb begin
      ctl       = '0;
      count_in  = count_ff;
      status_in = pls_pkg::STAT_RANGE;
      unique case (req_item.req_type)
         pls_pkg::KIND_INSERT: begin
            if (pos > count_ext) begin
               status_in = pls_pkg::STAT_RANGE;
            end else if (count_ext == FULL_MARK) begin
               status_in = pls_pkg::STAT_FULL;
            end else begin
               status_in     = pls_pkg::STAT_DONE;
               ctl.insert_go = accept;
               count_in      = count_ff + CW'(1);
            end
         end
         pls_pkg::KIND_REMOVE: begin
            if (pos < count_ext) begin
               status_in     = pls_pkg::STAT_DONE;
               ctl.remove_go = accept;
               ctl.pick_go   = accept;
               count_in      = count_ff - CW'(1);
            end
         end
         pls_pkg::KIND_READ: begin
            if (pos < count_ext) begin
               status_in   = pls_pkg::STAT_DONE;
               ctl.pick_go = accept;
            end
         end
         default: begin
            status_in = pls_pkg::STAT_RANGE;
         end
      endcase
   end

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic signed [pls_pkg::VALUE_W-1:0] left_value;
         logic signed [pls_pkg::VALUE_W-1:0] right_value;
         if (i == 0) begin : g_first
            assign left_value = '0;
         end else begin : g_mid_l
            assign left_value = cell_entry[i-1];
         end
         if (i == DEPTH - 1) begin : g_last
            assign right_value = '0;
         end else begin : g_mid_r
            assign right_value = cell_entry[i+1];
         end
         pls_cell #(
            .INDEX(i),
            .PW   (PW)
         ) u_cell (
            .clock      (clock),
            .ctl        (ctl),
            .pos        (pos),
            .left_value (left_value),
            .right_value(right_value),
            .new_value  (req_item.item_value),
            .entry      (cell_entry[i]),
            .pick       (cell_pick[i])
         );
      end

      for (i = 0; i < GROUPS * GROUP; i++) begin : g_pad
         if (i < DEPTH) begin : g_real
            assign pick_pad[i] = cell_pick[i];
         end else begin : g_zero
            assign pick_pad[i] = '0;
         end
      end

      for (i = 0; i < GROUPS; i++) begin : g_group
         always_comb begin
            group_in[i] = '0;
            for (int j = 0; j < GROUP; j++) begin
               group_in[i] = group_in[i] | pick_pad[i*GROUP + j];
            end
         end

         always_ff @(posedge clock) begin
            if (accept) begin
               group_ff[i] <= group_in[i];
            end
         end
      end
   endgenerate

   always_comb begin
      value_out = '0;
      for (int g = 0; g < GROUPS; g++) begin
         value_out = value_out | group_ff[g];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         pend_ff <= accept;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff <= status_in;
      end
   end

   assign rsp_strobe           = pend_ff;
   assign rsp_item.status      = status_ff;
   assign rsp_item.out_value   = value_out;
   assign rsp_item.entry_count = pls_pkg::COUNT_W'(count_ff);

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ext <= FULL_MARK)
      else $error("entry count exceeds the list depth");

   a_one_result : assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> rsp_strobe)
      else $error("accepted request produced no result");

   a_error_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_item.status != pls_pkg::STAT_DONE) |-> rsp_item.out_value == '0)
      else $error("error result carries a nonzero value");

   a_error_keeps_count : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_item.status != pls_pkg::STAT_DONE) |-> $stable(count_ff))
      else $error("refused request changed the entry count");

endmodule
